>>> src/hmnc_pkg.sv
// ----------------------------------------------------------------------------
// hmnc_pkg: shared types and constants for the heatmap colormap core
// Request kinds, color scheme codes, sequencer states and mapping constants.
// ----------------------------------------------------------------------------
package hmnc_pkg;

   // request kind carried in tuser bit 0
   localparam logic REQ_MEASURE = 1'b0;
   localparam logic REQ_COLOR   = 1'b1;

   localparam logic [7:0] WEIGHT_MAX = 8'd255;

   // floor(w*64/100) == floor(w*20976 / 2^15) for every 8-bit w
   localparam logic [23:0] ORANGE_RECIP = 24'd20976;
   localparam int          ORANGE_SHIFT = 15;

   typedef enum logic [3:0] {
      SCHEME_GREY   = 4'd0,
      SCHEME_BLUE   = 4'd1,
      SCHEME_PURPLE = 4'd2,
      SCHEME_RED    = 4'd3,
      SCHEME_GREEN  = 4'd4,
      SCHEME_YELLOW = 4'd5,
      SCHEME_HEAT   = 4'd6,
      SCHEME_ORANGE = 4'd7,
      SCHEME_PLASMA = 4'd8,
      SCHEME_GRAPE  = 4'd9
   } hmnc_scheme_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAN,
      ST_HIGH,
      ST_LOW,
      ST_SCALE,
      ST_DIV,
      ST_MAP
   } hmnc_state_type;

endpackage

>>> src/heatmap_normalize_colormap_core.sv
// ----------------------------------------------------------------------------
// heatmap_normalize_colormap_core: min/max normalize and colormap
// Measure transactions track the sample range; color transactions scale a
// sample to 0..255 with one shared subtractor and apply the color scheme.
// ----------------------------------------------------------------------------
// Measure transaction: next transaction accepted in the next cycle.
// Color transaction: in the usual case it steps through the range checks
//   (SPAN, HIGH, LOW), SCALE, DIV (one quotient bit per cycle) and MAP;
//   flat or out-of-range samples go from a range check straight to MAP.
// The next transaction can be accepted in the same cycle that rsp_tvalid
// rises; a response held by rsp_tready stalls the map step.
// Reset (synchronous, active high) clears the range, the scheme and the FSM.
module heatmap_normalize_colormap_core #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   // tdata: sample_value (low SAMPLE_WIDTH bits), zero padded to bytes
   input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser: [0] req_type, [1] first_sample
   input  logic [1:0]  req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: weight [7:0], red [15:8], green [23:16], blue [31:24]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [3:0]  csr_wdata,
   input  logic        csr_valid,
   output logic        csr_ready
);
   import hmnc_pkg::*;

   localparam int SubW = SAMPLE_WIDTH + 10;

   hmnc_state_type state_ff, state_in;

   logic signed [SAMPLE_WIDTH-1:0] range_low_ff, range_low_in;
   logic signed [SAMPLE_WIDTH-1:0] range_high_ff, range_high_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic        [3:0]              scheme_ff;
   logic signed [SubW-1:0]         acc_ff, acc_in;
   logic signed [SubW-1:0]         span_ff, span_in;
   logic        [7:0]              weight_ff, weight_in;
   logic        [2:0]              cnt_ff, cnt_in;
   logic        [31:0]             rsp_data_ff, rsp_data_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic signed [SubW-1:0] sub_a, sub_b, sub_res;
   logic                   sub_neg, sub_nonpos;

   logic signed [SAMPLE_WIDTH-1:0] req_sample;
   logic                           req_fire, out_free;
   logic        [7:0]              red, green, blue;
   logic        [23:0]             orange_prod;

   function automatic logic signed [SubW-1:0] sext(input logic [SAMPLE_WIDTH-1:0] x);
      sext = {{(SubW - SAMPLE_WIDTH){x[SAMPLE_WIDTH-1]}}, x};
   endfunction

   assign req_sample = req_tdata[SAMPLE_WIDTH-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // shared subtractor
   assign sub_res    = sub_a - sub_b;
   assign sub_neg    = sub_res[SubW-1];
   assign sub_nonpos = sub_neg || (sub_res == '0);

   always_comb begin
      sub_a = acc_ff;
      sub_b = span_ff << cnt_ff;
      case (state_ff)
         ST_SPAN: begin
            sub_a = sext(range_high_ff);
            sub_b = sext(range_low_ff);
         end
         ST_HIGH: begin
            sub_a = sext(sample_ff);
            sub_b = sext(range_high_ff);
         end
         ST_LOW: begin
            sub_a = sext(sample_ff);
            sub_b = sext(range_low_ff);
         end
         ST_SCALE: begin
            sub_a = {acc_ff[SubW-9:0], 8'd0};
            sub_b = acc_ff;
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tuser[0] == REQ_COLOR) begin
               state_in = ST_SPAN;
            end
         end
         ST_SPAN:  state_in = sub_nonpos ? ST_MAP : ST_HIGH;
         ST_HIGH:  state_in = !sub_neg ? ST_MAP : ST_LOW;
         ST_LOW:   state_in = sub_nonpos ? ST_MAP : ST_SCALE;
         ST_SCALE: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == 3'd0) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // color map of the finished weight
   assign orange_prod = {16'd0, weight_ff} * ORANGE_RECIP;

   always_comb begin
      red   = 8'd0;
      green = 8'd0;
      blue  = 8'd0;
      case (hmnc_scheme_type'(scheme_ff))
         SCHEME_GREY: begin
            red   = weight_ff;
            green = weight_ff;
            blue  = weight_ff;
         end
         SCHEME_BLUE:   blue = weight_ff;
         SCHEME_PURPLE: begin
            red  = weight_ff;
            blue = weight_ff;
         end
         SCHEME_RED:    red = weight_ff;
         SCHEME_GREEN:  green = weight_ff;
         SCHEME_YELLOW: begin
            red   = weight_ff;
            green = weight_ff;
         end
         SCHEME_HEAT: begin
            red   = weight_ff;
            green = WEIGHT_MAX - weight_ff;
         end
         SCHEME_ORANGE: begin
            red   = weight_ff;
            green = orange_prod[ORANGE_SHIFT+7:ORANGE_SHIFT];
         end
         SCHEME_PLASMA: begin
            green = weight_ff;
            blue  = WEIGHT_MAX - weight_ff;
         end
         SCHEME_GRAPE: begin
            red  = weight_ff;
            blue = WEIGHT_MAX - weight_ff;
         end
         default: begin
         end
      endcase
   end

   // datapath and output control
   always_comb begin
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      sample_in     = sample_ff;
      acc_in        = acc_ff;
      span_in       = span_ff;
      weight_in     = weight_ff;
      cnt_in        = cnt_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sample_in = req_sample;
               if (req_tuser[0] == REQ_MEASURE) begin
                  if (req_tuser[1]) begin
                     range_low_in  = req_sample;
                     range_high_in = req_sample;
                  end else begin
                     if (req_sample > range_high_ff) begin
                        range_high_in = req_sample;
                     end
                     if (req_sample < range_low_ff) begin
                        range_low_in = req_sample;
                     end
                  end
               end
            end
         end
         ST_SPAN: begin
            span_in   = sub_res;
            weight_in = 8'd0;
         end
         ST_HIGH: begin
            weight_in = WEIGHT_MAX;
         end
         ST_LOW: begin
            acc_in    = sub_res;
            weight_in = 8'd0;
         end
         ST_SCALE: begin
            acc_in = sub_res;
            cnt_in = 3'd7;
         end
         ST_DIV: begin
            // restoring step: keep the remainder when the trial goes negative
            if (!sub_neg) begin
               acc_in = sub_res;
            end
            weight_in = {weight_ff[6:0], !sub_neg};
            cnt_in    = cnt_ff - 3'd1;
         end
         ST_MAP: begin
            if (out_free) begin
               rsp_data_in  = {blue, green, red, weight_ff};
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         scheme_ff     <= 4'd0;
         range_low_ff  <= '0;
         range_high_ff <= '0;
         cnt_ff        <= 3'd0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
         cnt_ff        <= cnt_in;
         if (csr_valid && csr_ready) begin
            scheme_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      acc_ff      <= acc_in;
      span_ff     <= span_in;
      weight_ff   <= weight_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> src/hmnc_checker.sv
// ----------------------------------------------------------------------------
// hmnc_checker: port-level checks for the heatmap colormap core
// Watches the request, response and register ports over time.
// ----------------------------------------------------------------------------
module hmnc_checker #(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic clock,
   input logic reset,
   input logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [3:0]  csr_wdata,
   input logic        csr_valid,
   input logic        csr_ready
);
   import hmnc_pkg::*;

   logic req_fire;
   logic [7:0] weight, red, blue;

   assign req_fire = req_tvalid && req_tready;
   assign weight   = rsp_tdata[7:0];
   assign red      = rsp_tdata[15:8];
   assign blue     = rsp_tdata[31:24];

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // a color transaction keeps the block busy for the next cycle
   a_color_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser[0] == REQ_COLOR |=> !req_tready)
      else $error("ready right after a color transaction");

   // a measure transaction leaves the block ready
   a_measure_ready: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser[0] == REQ_MEASURE |=> req_tready)
      else $error("not ready after a measure transaction");

   // red always follows the weight or stays dark
   a_red_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (red == weight || red == 8'd0))
      else $error("red byte not derived from weight");

   // blue is dark, the weight or its complement
   a_blue_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (blue == 8'd0 || blue == weight || blue == WEIGHT_MAX - weight))
      else $error("blue byte not derived from weight");

endmodule

bind heatmap_normalize_colormap_core hmnc_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_hmnc_checker (.*);

>>> tb/hmnc_pixel_checker.sv
// ----------------------------------------------------------------------------
// hmnc_pixel_checker: predicts and checks heatmap colormap results
// Watches the request, response and CSR channels of the colormap core. Keeps
// its own sample range and scheme, predicts one pixel per color transaction,
// and compares every response field against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module hmnc_pixel_checker #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [3:0]  csr_wdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   output int          fail_count,
   output int          outstanding
);
   import hmnc_pkg::*;

   // packed so that weight lands in bits [7:0], as on rsp_tdata
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] weight;
   } pixel_type;

   logic signed [SAMPLE_WIDTH-1:0] lo_seen;
   logic signed [SAMPLE_WIDTH-1:0] hi_seen;
   logic [3:0]                     scheme_sel;
   pixel_type                      pending_pixels[$];
   int                             mismatches = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_byte(input string field, input logic [7:0] want,
                             input logic [7:0] got);
      if (want !== got)
         report_mismatch($sformatf("%s expected %0d got %0d", field, want, got));
   endtask

   // exact integer min/max scaling, clamped to 0..255
   function automatic logic [7:0] scale_to_weight(logic signed [SAMPLE_WIDTH-1:0] v);
      longint lo;
      longint hi;
      longint x;
      longint q;
      lo = lo_seen;
      hi = hi_seen;
      x  = v;
      if (hi <= lo || x <= lo)
         return 8'd0;
      if (x >= hi)
         return WEIGHT_MAX;
      q = ((x - lo) * 255) / (hi - lo);
      return q[7:0];
   endfunction

   function automatic pixel_type predict_pixel(logic signed [SAMPLE_WIDTH-1:0] v);
      pixel_type  px;
      logic [7:0] w;
      int         orange_g;
      w        = scale_to_weight(v);
      px       = '0;
      px.weight = w;
      orange_g = (int'(w) * 64) / 100;
      case (scheme_sel)
         SCHEME_GREY:   begin px.red = w; px.green = w; px.blue = w; end
         SCHEME_BLUE:   px.blue = w;
         SCHEME_PURPLE: begin px.red = w; px.blue = w; end
         SCHEME_RED:    px.red = w;
         SCHEME_GREEN:  px.green = w;
         SCHEME_YELLOW: begin px.red = w; px.green = w; end
         SCHEME_HEAT:   begin px.red = w; px.green = WEIGHT_MAX - w; end
         SCHEME_ORANGE: begin px.red = w; px.green = orange_g[7:0]; end
         SCHEME_PLASMA: begin px.green = w; px.blue = WEIGHT_MAX - w; end
         SCHEME_GRAPE:  begin px.red = w; px.blue = WEIGHT_MAX - w; end
         default:       ; // unused codes keep only the weight
      endcase
      return px;
   endfunction

   always @(posedge clock) begin
      pixel_type                      want;
      pixel_type                      got;
      logic signed [SAMPLE_WIDTH-1:0] v;
      if (reset) begin
         lo_seen    = '0;
         hi_seen    = '0;
         scheme_sel = SCHEME_GREY;
         pending_pixels.delete();
      end else begin
         if (csr_valid && csr_ready)
            scheme_sel = csr_wdata;

         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_pixels.size() == 0) begin
               report_mismatch($sformatf("response 0x%08h with nothing expected",
                                         rsp_tdata));
            end else begin
               want = pending_pixels.pop_front();
               check_byte("weight", want.weight, got.weight);
               check_byte("red",    want.red,    got.red);
               check_byte("green",  want.green,  got.green);
               check_byte("blue",   want.blue,   got.blue);
            end
         end

         if (req_tvalid && req_tready) begin
            v = req_tdata[SAMPLE_WIDTH-1:0];
            if (req_tuser[0] == REQ_COLOR) begin
               pending_pixels.push_back(predict_pixel(v));
            end else if (req_tuser[1]) begin
               // restart the range at this sample
               lo_seen = v;
               hi_seen = v;
            end else begin
               if (v > hi_seen)
                  hi_seen = v;
               if (v < lo_seen)
                  lo_seen = v;
            end
         end
      end
      outstanding <= pending_pixels.size();
   end

endmodule

>>> tb/tb_heatmap_normalize_colormap_core.sv
// ----------------------------------------------------------------------------
// tb_heatmap_normalize_colormap_core: stimulus and verdict for the core
// Drives measure and color transactions with random gaps and backpressure,
// steps through every color scheme code, and lets hmnc_pixel_checker
// predict and compare each response.
// ----------------------------------------------------------------------------
module tb_heatmap_normalize_colormap_core;
   import hmnc_pkg::*;

   localparam int SAMPLE_WIDTH = 16;
   localparam int REQ_W        = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int SAMPLE_MIN   = -(1 << (SAMPLE_WIDTH - 1));
   localparam int SAMPLE_MAX   = (1 << (SAMPLE_WIDTH - 1)) - 1;
   localparam int RANDOM_ITEMS = 500;
   localparam int PHASE_ITEMS  = 30;
   localparam int DRAIN_CYCLES = 24;
   localparam int LONG_HOLD    = 400;
   localparam int RUN_LIMIT    = 600000;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic [1:0]       req_tuser  = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [31:0]      rsp_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [3:0]       csr_wdata  = SCHEME_GREY;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;

   int fail_count;
   int outstanding;
   int cycle_count = 0;
   int items_sent  = 0;
   bit no_idle     = 1'b0;
   bit squeeze_req = 1'b0;

   heatmap_normalize_colormap_core #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wdata  (csr_wdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   hmnc_pixel_checker #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_pixel_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wdata   (csr_wdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int clamp_sample(int v);
      if (v < SAMPLE_MIN)
         return SAMPLE_MIN;
      if (v > SAMPLE_MAX)
         return SAMPLE_MAX;
      return v;
   endfunction

   // offer one transaction, hold it until accepted, then maybe idle
   task automatic send_item(input logic kind, input int value, input logic first);
      int gap;
      req_tdata  <= REQ_W'(value);
      req_tuser  <= {first, kind};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // block is idle once all results are in and any trailing measure is done
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_scheme(input logic [3:0] code);
      csr_wdata <= code;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // one well-formed range frame: restart, widen, then color samples
   task automatic run_frame();
      int lo;
      int span;
      int margin;
      int r;
      int n;
      r = $urandom_range(0, 9);
      if (r == 0)
         span = 0;
      else if (r < 5)
         span = $urandom_range(1, 300);
      else if (r < 8)
         span = $urandom_range(301, 5000);
      else
         span = $urandom_range(5001, SAMPLE_MAX - SAMPLE_MIN);
      lo     = SAMPLE_MIN + int'($urandom_range(0, SAMPLE_MAX - SAMPLE_MIN - span));
      margin = span / 8 + 2;
      send_item(REQ_MEASURE, lo + int'($urandom_range(0, span)), 1'b1);
      n = $urandom_range(0, 5);
      repeat (n)
         send_item(REQ_MEASURE, lo + int'($urandom_range(0, span)), 1'b0);
      n = $urandom_range(1, 6);
      repeat (n)
         send_item(REQ_COLOR,
                   clamp_sample(lo - margin + int'($urandom_range(0, span + 2 * margin))),
                   1'($urandom_range(0, 1)));
   endtask

   task automatic run_noise();
      int n;
      n = $urandom_range(1, 3);
      repeat (n)
         send_item(1'($urandom_range(0, 1)), int'($urandom), 1'($urandom_range(0, 1)));
   endtask

   // receiver: random stalls, plus one long hold-off to back up the input
   initial begin
      int stall;
      int run;
      bit held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (squeeze_req && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge clock);
         end
      end
   end

   initial begin
      int phase;
      int phase_start;
      int random_start;
      logic [3:0] code;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: flat range straight after reset, scheme at its reset value
      send_item(REQ_COLOR,   5,          1'b0);
      send_item(REQ_MEASURE, SAMPLE_MIN, 1'b1);
      send_item(REQ_COLOR,   SAMPLE_MIN, 1'b0);
      // widest range, both ends and the middle
      send_item(REQ_MEASURE, SAMPLE_MAX, 1'b0);
      send_item(REQ_MEASURE, 0,          1'b0);
      send_item(REQ_COLOR,   SAMPLE_MIN, 1'b0);
      send_item(REQ_COLOR,   SAMPLE_MAX, 1'b0);
      send_item(REQ_COLOR,   0,          1'b0);
      send_item(REQ_COLOR,   -1,         1'b1); // first flag ignored on color
      // narrow range: below, above and inside
      send_item(REQ_MEASURE, 100,        1'b1);
      send_item(REQ_MEASURE, 200,        1'b0);
      send_item(REQ_COLOR,   50,         1'b0);
      send_item(REQ_COLOR,   300,        1'b0);
      send_item(REQ_COLOR,   150,        1'b0);
      send_item(REQ_COLOR,   199,        1'b0);
      send_item(REQ_COLOR,   101,        1'b0);
      // lower the low end without a restart
      send_item(REQ_MEASURE, 20,         1'b0);
      send_item(REQ_COLOR,   20,         1'b0);
      send_item(REQ_COLOR,   110,        1'b0);
      send_item(REQ_MEASURE, -7,         1'b0);
      send_item(REQ_COLOR,   SAMPLE_MAX, 1'b0);
      wait_idle();

      // random: walk every scheme code first, then random codes
      random_start = items_sent;
      phase = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if (phase < 16)
            code = 4'(phase);
         else if ($urandom_range(0, 7) == 0)
            code = 4'($urandom_range(SCHEME_GRAPE + 1, 15));
         else
            code = 4'($urandom_range(SCHEME_GREY, SCHEME_GRAPE));
         write_scheme(code);
         no_idle = ($urandom_range(0, 3) == 0);
         if (phase == 1)
            squeeze_req = 1'b1;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 15)
               run_noise();
            else
               run_frame();
         end
         wait_idle();
         phase++;
      end

      if (fail_count == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
